@@ design/ntc_pkg.sv @@
// Shared constants, types and the thermistor resistance table.
package ntc_pkg;

   localparam int SERIES_BITS   = 16;
   localparam int OHM_BITS      = 16;
   localparam int TABLE_ENTRIES = 121;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int FRACTION_BITS = 4;
   localparam int FRAC_Q_BITS   = FRACTION_BITS + 1;
   localparam int TEMP_BITS     = 12;
   localparam int TEMP_FIRST    = -10;

   localparam logic [SERIES_BITS-1:0] SERIES_RESET = SERIES_BITS'(15000);
   localparam logic [TEMP_BITS-1:0] TEMP_LOW =
      TEMP_BITS'(TEMP_FIRST * (1 << FRACTION_BITS));
   localparam logic [TEMP_BITS-1:0] TEMP_HIGH =
      TEMP_BITS'((TEMP_FIRST + TABLE_ENTRIES - 1) * (1 << FRACTION_BITS));
   // Whole degrees of the entry before the matched one, relative to the index.
   localparam logic [TEMP_BITS-1:0] DEG_OFFSET = TEMP_BITS'(TEMP_FIRST - 1);

   // Resistance in ohms, one entry per degree from -10 degrees, falling.
   localparam logic [OHM_BITS-1:0] ROM_OHMS [TABLE_ENTRIES] = '{
      16'd55340, 16'd52420, 16'd49660, 16'd47080, 16'd44640,
      16'd42340, 16'd40160, 16'd38120, 16'd36200, 16'd34380,
      16'd32660, 16'd31040, 16'd29500, 16'd28060, 16'd26680,
      16'd25400, 16'd24180, 16'd23020, 16'd21920, 16'd20880,
      16'd19900, 16'd18970, 16'd18090, 16'd17260, 16'd16460,
      16'd15710, 16'd15000, 16'd14320, 16'd13680, 16'd13070,
      16'd12490, 16'd11940, 16'd11420, 16'd10920, 16'd10450,
      16'd10000, 16'd9574,  16'd9166,  16'd8778,  16'd8408,
      16'd8058,  16'd7722,  16'd7404,  16'd7098,  16'd6808,
      16'd6532,  16'd6268,  16'd6016,  16'd5776,  16'd5546,
      16'd5326,  16'd5118,  16'd4918,  16'd4726,  16'd4544,
      16'd4368,  16'd4202,  16'd4042,  16'd3888,  16'd3742,
      16'd3602,  16'd3468,  16'd3340,  16'd3216,  16'd3098,
      16'd2986,  16'd2878,  16'd2774,  16'd2674,  16'd2580,
      16'd2488,  16'd2400,  16'd2316,  16'd2234,  16'd2158,
      16'd2082,  16'd2012,  16'd1942,  16'd1876,  16'd1813,
      16'd1751,  16'd1693,  16'd1637,  16'd1582,  16'd1530,
      16'd1480,  16'd1432,  16'd1385,  16'd1341,  16'd1298,
      16'd1256,  16'd1216,  16'd1178,  16'd1141,  16'd1105,
      16'd1071,  16'd1038,  16'd1006,  16'd975,   16'd945,
      16'd916,   16'd888,   16'd862,   16'd836,   16'd811,
      16'd787,   16'd764,   16'd741,   16'd720,   16'd699,
      16'd679,   16'd659,   16'd640,   16'd622,   16'd605,
      16'd588,   16'd571,   16'd555,   16'd540,   16'd525,
      16'd510
   };

   // Outcome of the table search.
   typedef struct packed {
      logic [IDX_BITS-1:0] idx;
      logic                below;
      logic                above;
   } seg_type;

   function automatic logic [OHM_BITS-1:0] rom_ohms(input logic [IDX_BITS-1:0] idx);
      logic [OHM_BITS-1:0] val;
      val = '0;
      if (idx < IDX_BITS'(TABLE_ENTRIES)) begin
         val = ROM_OHMS[idx];
      end
      return val;
   endfunction

endpackage

@@ design/ntc_res_calc.sv @@
// Serial shift-add multiplier and restoring divider for the thermistor resistance.
module ntc_res_calc import ntc_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [SERIES_BITS-1:0]            series,
   input  logic [ADC_BITS-1:0]               code,
   output logic                              done,
   output logic [SERIES_BITS+ADC_BITS-1:0]   ohms
);

   localparam int PROD_BITS = SERIES_BITS + ADC_BITS;
   localparam int DEN_BITS  = ADC_BITS + 1;
   localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

   typedef enum logic [1:0] {IDLE, MUL, DIV} state_type;

   state_type             state_ff;
   logic                  done_ff;
   logic [PROD_BITS-1:0]  quo_ff;
   logic [PROD_BITS-1:0]  mcand_ff;
   logic [ADC_BITS-1:0]   mplier_ff;
   logic [DEN_BITS-1:0]   den_ff;
   logic [DEN_BITS-1:0]   rem_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic [DEN_BITS:0]     trial_in;
   logic                  qbit_in;
   logic [DEN_BITS-1:0]   rem_in;

   // One quotient bit per cycle; the dividend shifts out of the top of quo_ff
   // while quotient bits shift in at the bottom.
   always_comb begin
      trial_in = {rem_ff, quo_ff[PROD_BITS-1]};
      qbit_in  = (trial_in >= {1'b0, den_ff});
      rem_in   = qbit_in ? DEN_BITS'(trial_in - {1'b0, den_ff})
                         : trial_in[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == DIV) && (cnt_ff == CNT_BITS'(PROD_BITS - 1));
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  mcand_ff  <= PROD_BITS'(series);
                  mplier_ff <= code;
                  quo_ff    <= '0;
                  den_ff    <= DEN_BITS'(1 << ADC_BITS) - DEN_BITS'(code);
                  cnt_ff    <= '0;
                  state_ff  <= MUL;
               end
            end
            MUL: begin
               if (mplier_ff[0]) begin
                  quo_ff <= quo_ff + mcand_ff;
               end
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               if (cnt_ff == CNT_BITS'(ADC_BITS - 1)) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  state_ff <= DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            DIV: begin
               quo_ff <= {quo_ff[PROD_BITS-2:0], qbit_in};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(PROD_BITS - 1)) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign ohms = quo_ff;

endmodule

@@ design/ntc_tbl_search.sv @@
// Binary search of the falling resistance table for the first entry not above R.
module ntc_tbl_search import ntc_pkg::*; #(
   parameter int OHMS_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [OHMS_BITS-1:0]  ohms,
   output logic                  done,
   output seg_type               seg
);

   typedef enum logic {IDLE, SEARCH} state_type;

   state_type            state_ff;
   logic                 done_ff;
   seg_type              seg_ff;
   logic [IDX_BITS-1:0]  lo_ff;
   logic [IDX_BITS-1:0]  hi_ff;

   logic [IDX_BITS:0]    sum_in;
   logic [IDX_BITS-1:0]  mid_in;
   logic                 fits_in;

   always_comb begin
      sum_in  = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid_in  = sum_in[IDX_BITS:1];
      fits_in = (OHMS_BITS'(rom_ohms(mid_in)) <= ohms);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == SEARCH) && (lo_ff == hi_ff);
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  lo_ff    <= '0;
                  hi_ff    <= IDX_BITS'(TABLE_ENTRIES - 1);
                  state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               if (lo_ff == hi_ff) begin
                  // Past either end the index stops at the end entry; the flags
                  // tell whether R lies strictly outside the table.
                  seg_ff.idx   <= lo_ff;
                  seg_ff.below <= (lo_ff == '0) &&
                                  (ohms > OHMS_BITS'(rom_ohms('0)));
                  seg_ff.above <= (lo_ff == IDX_BITS'(TABLE_ENTRIES - 1)) &&
                                  (ohms < OHMS_BITS'(rom_ohms(
                                      IDX_BITS'(TABLE_ENTRIES - 1))));
                  state_ff     <= IDLE;
               end else if (fits_in) begin
                  hi_ff <= mid_in;
               end else begin
                  lo_ff <= mid_in + 1'b1;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign seg  = seg_ff;

endmodule

@@ design/ntc_frac_div.sv @@
// Serial divider for the interpolated fraction between two table entries.
module ntc_frac_div import ntc_pkg::*; #(
   parameter int OHMS_BITS = 28
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OHMS_BITS-1:0]    ohms,
   input  logic [IDX_BITS-1:0]     idx,
   output logic                    done,
   output logic [FRAC_Q_BITS-1:0]  frac
);

   localparam int CNT_BITS = $clog2(FRAC_Q_BITS + 1);

   typedef enum logic {IDLE, DIV} state_type;

   state_type               state_ff;
   logic                    done_ff;
   logic [OHM_BITS:0]       rem_ff;
   logic [OHM_BITS-1:0]     span_ff;
   logic [FRAC_Q_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]     cnt_ff;

   logic [OHM_BITS-1:0]     hi_in;
   logic [OHM_BITS-1:0]     lo_in;
   logic                    qbit_in;
   logic [OHM_BITS:0]       diff_in;

   // Only meaningful when entry idx-1 > R >= entry idx, so R fits the table width.
   always_comb begin
      hi_in   = rom_ohms(idx - 1'b1);
      lo_in   = rom_ohms(idx);
      qbit_in = (rem_ff >= {1'b0, span_ff});
      diff_in = qbit_in ? (rem_ff - {1'b0, span_ff}) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == DIV) && (cnt_ff == CNT_BITS'(FRAC_Q_BITS - 1));
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  span_ff  <= hi_in - lo_in;
                  rem_ff   <= {1'b0, hi_in - ohms[OHM_BITS-1:0]};
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= DIV;
               end
            end
            DIV: begin
               quo_ff <= FRAC_Q_BITS'({quo_ff, qbit_in});
               rem_ff <= {diff_in[OHM_BITS-1:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(FRAC_Q_BITS - 1)) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign frac = quo_ff;

endmodule

@@ design/ntc_thermistor_temperature.sv @@
// NTC thermistor temperature: top level with sequencer, register and result stage.
//
// Each transferred ADC code becomes one temperature in signed sixteenths of a
// degree, clamped to -10..110 degrees, with below_range or above_range set when
// the thermistor resistance lies outside the table. One item is worked on at a
// time: the next code is taken only after the result has gone into the output
// register. Most of the work is the bit-serial resistance division after a
// serial multiply; the table search and the fraction division follow. A
// finished result waits in the output register while the next code is already
// taken.
// csr_data sets the series resistor in ohms (15000 after reset); write it only
// while no item is in flight.
module ntc_thermistor_temperature import ntc_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [SERIES_BITS-1:0]        csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ADC_BITS-1:0]           req_adc_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [TEMP_BITS-1:0]   rsp_temp_sixteenths,
   output logic                          rsp_below_range,
   output logic                          rsp_above_range
);

   localparam int OHMS_BITS = SERIES_BITS + ADC_BITS;

   typedef enum logic [2:0] {IDLE, RES, SEARCH, FRAC, FINISH} state_type;

   state_type                    state_ff;
   logic [SERIES_BITS-1:0]       series_ff;
   logic                         rsp_valid_ff;
   logic signed [TEMP_BITS-1:0]  rsp_temp_ff;
   logic                         rsp_below_ff;
   logic                         rsp_above_ff;

   logic                         accept_in;
   logic                         res_done;
   logic [OHMS_BITS-1:0]         ohms;
   logic                         srch_done;
   seg_type                      seg;
   logic                         frac_done;
   logic [FRAC_Q_BITS-1:0]       frac;
   logic                         out_free_in;
   logic [TEMP_BITS-1:0]         temp_in;

   assign accept_in   = req_valid && !req_stall;
   assign out_free_in = !rsp_valid_ff || !rsp_stall;

   ntc_res_calc #(.ADC_BITS(ADC_BITS)) u_res (
      .clock  (clock),
      .reset  (reset),
      .start  (accept_in),
      .series (series_ff),
      .code   (req_adc_code),
      .done   (res_done),
      .ohms   (ohms)
   );

   ntc_tbl_search #(.OHMS_BITS(OHMS_BITS)) u_srch (
      .clock (clock),
      .reset (reset),
      .start (res_done && (state_ff == RES)),
      .ohms  (ohms),
      .done  (srch_done),
      .seg   (seg)
   );

   ntc_frac_div #(.OHMS_BITS(OHMS_BITS)) u_frac (
      .clock (clock),
      .reset (reset),
      .start (srch_done && (state_ff == SEARCH)),
      .ohms  (ohms),
      .idx   (seg.idx),
      .done  (frac_done),
      .frac  (frac)
   );

   // The first entry and anything above it read as -10 degrees; below the
   // last entry reads as 110 degrees; otherwise interpolate from entry idx-1.
   always_comb begin
      if (seg.idx == '0) begin
         temp_in = TEMP_LOW;
      end else if (seg.above) begin
         temp_in = TEMP_HIGH;
      end else begin
         temp_in = ((TEMP_BITS'(seg.idx) + DEG_OFFSET) << FRACTION_BITS)
                   + TEMP_BITS'(frac);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         series_ff    <= SERIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            series_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept_in) begin
                  state_ff <= RES;
               end
            end
            RES: begin
               if (res_done) begin
                  state_ff <= SEARCH;
               end
            end
            SEARCH: begin
               if (srch_done) begin
                  state_ff <= FRAC;
               end
            end
            FRAC: begin
               if (frac_done) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free_in) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_temp_ff  <= $signed(temp_in);
                  rsp_below_ff <= seg.below;
                  rsp_above_ff <= seg.above;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign csr_ready           = 1'b1;
   assign req_stall           = (state_ff != IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temp_sixteenths = rsp_temp_ff;
   assign rsp_below_range     = rsp_below_ff;
   assign rsp_above_range     = rsp_above_ff;

endmodule

@@ design/ntc_checker.sv @@
// Port-level assertions for the thermistor temperature block, bound to the top level.
module ntc_checker import ntc_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [ADC_BITS-1:0]           req_adc_code,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [TEMP_BITS-1:0]   rsp_temp_sixteenths,
   input logic                          rsp_below_range,
   input logic                          rsp_above_range
);

   // A stalled request keeps its code until it is transferred.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_adc_code))
      else $error("request changed while stalled");

   // A stalled result holds until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_sixteenths)
         && $stable(rsp_below_range) && $stable(rsp_above_range))
      else $error("result changed while stalled");

   // After an input transfer the block is busy with that code.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again without a busy cycle");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_below_range && rsp_above_range))
      else $error("both range flags set");

   a_clamp_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_below_range || rsp_temp_sixteenths == $signed(TEMP_LOW))
         && (!rsp_above_range || rsp_temp_sixteenths == $signed(TEMP_HIGH)))
      else $error("range flag without clamped temperature");

endmodule

bind ntc_thermistor_temperature ntc_checker #(.ADC_BITS(ADC_BITS)) u_ntc_checker (.*);
